FILE: hdl/deadlock_avoidance_grant_checker_core_assert.svh
// Assertion macros for the grant checker core.
// Used by the checker module only; expects i_clk and i_rst_n in scope.
`ifndef DEADLOCK_AVOIDANCE_GRANT_CHECKER_CORE_ASSERT_SVH
`define DEADLOCK_AVOIDANCE_GRANT_CHECKER_CORE_ASSERT_SVH

// same-cycle implication
`define DAGC_AST_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DAGC_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/dagc_pkg.sv
// Shared constants, codes and types for the grant checker core.
// No dependencies; imported by every module of the block.
package dagc_pkg;

    localparam int PROCESSES_DEF  = 5;
    localparam int RESOURCES_DEF  = 4;
    localparam int COUNT_BITS_DEF = 8;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 8;
    localparam int REQ_FIELDS  = 4;

    localparam logic [2:0] MODE_AVAIL = 3'd0;
    localparam logic [2:0] MODE_MAX   = 3'd1;
    localparam logic [2:0] MODE_ALLOC = 3'd2;
    localparam logic [2:0] MODE_REQ   = 3'd3;
    localparam logic [2:0] MODE_CHECK = 3'd4;

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_OK     = 3'd1;
    localparam logic [2:0] ST_CLAIM  = 3'd2;
    localparam logic [2:0] ST_AVAIL  = 3'd3;
    localparam logic [2:0] ST_UNSAFE = 3'd4;

    typedef struct packed {
        logic wr_max;
        logic wr_alloc;
        logic add_req;
        logic sub_req;
        logic scan_clr;
    } t_lane_cmd;

endpackage

FILE: hdl/dagc_lane.sv
// One process lane: claim and allocation rows, need, fit test, finish flag.
// Depends on dagc_pkg.
module dagc_lane import dagc_pkg::*; #(
    parameter int RESOURCES  = RESOURCES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int WORK_BITS  = COUNT_BITS_DEF + 3
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  t_lane_cmd                             i_cmd,
    input  logic                                  i_sel,
    input  logic                                  i_grant,
    input  logic [1:0]                            i_rid,
    input  logic [COUNT_BITS-1:0]                 i_val,
    input  logic [RESOURCES-1:0][COUNT_BITS-1:0]  i_req,
    input  logic [RESOURCES-1:0][WORK_BITS-1:0]   i_work,
    output logic                                  o_exceeds,
    output logic                                  o_fit,
    output logic                                  o_done,
    output logic [RESOURCES-1:0][COUNT_BITS-1:0]  o_alloc
);

    logic [RESOURCES-1:0][COUNT_BITS-1:0] r_max, n_max;
    logic [RESOURCES-1:0][COUNT_BITS-1:0] r_alloc, n_alloc;
    logic                                 r_done, n_done;
    logic [COUNT_BITS:0]                  need [RESOURCES];
    logic                                 fit_all;

    always_comb begin
        n_max     = r_max;
        n_alloc   = r_alloc;
        n_done    = r_done;
        o_exceeds = 1'b0;
        fit_all   = 1'b1;
        for (int r = 0; r < RESOURCES; r++) begin
            // sign bit set means allocation above claim
            need[r] = {1'b0, r_max[r]} - {1'b0, r_alloc[r]};
            if (need[r][COUNT_BITS] || (i_req[r] > need[r][COUNT_BITS-1:0])) begin
                o_exceeds = 1'b1;
            end
            if (!need[r][COUNT_BITS]
                && (WORK_BITS'(need[r][COUNT_BITS-1:0]) > i_work[r])) begin
                fit_all = 1'b0;
            end
            if (i_sel) begin
                if (i_cmd.wr_max && (32'(i_rid) == r)) begin
                    n_max[r] = i_val;
                end
                if (i_cmd.wr_alloc && (32'(i_rid) == r)) begin
                    n_alloc[r] = i_val;
                end
                if (i_cmd.add_req) begin
                    n_alloc[r] = r_alloc[r] + i_req[r];
                end
                if (i_cmd.sub_req) begin
                    n_alloc[r] = r_alloc[r] - i_req[r];
                end
            end
        end
        if (i_cmd.scan_clr) begin
            n_done = 1'b0;
        end else if (i_grant) begin
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= '0;
            r_alloc <= '0;
            r_done  <= 1'b0;
        end else begin
            r_max   <= n_max;
            r_alloc <= n_alloc;
            r_done  <= n_done;
        end
    end

    assign o_fit   = !r_done && fit_all;
    assign o_done  = r_done;
    assign o_alloc = r_alloc;

endmodule

FILE: hdl/dagc_merge.sv
// Merge stage: picks the lowest fitting lane and forwards its allocation row.
// Depends on dagc_pkg.
module dagc_merge import dagc_pkg::*; #(
    parameter int PROCESSES  = PROCESSES_DEF,
    parameter int RESOURCES  = RESOURCES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic [PROCESSES-1:0]                                 i_fit,
    input  logic [PROCESSES-1:0][RESOURCES-1:0][COUNT_BITS-1:0]  i_alloc,
    output logic [PROCESSES-1:0]                                 o_grant,
    output logic                                                 o_any,
    output logic [RESOURCES-1:0][COUNT_BITS-1:0]                 o_alloc
);

    logic found;

    always_comb begin
        found   = 1'b0;
        o_grant = '0;
        o_alloc = '0;
        for (int p = 0; p < PROCESSES; p++) begin
            if (i_fit[p] && !found) begin
                found      = 1'b1;
                o_grant[p] = 1'b1;
                o_alloc    = i_alloc[p];
            end
        end
    end

    assign o_any = |i_fit;

endmodule

FILE: hdl/deadlock_avoidance_grant_checker_core.sv
// Banker's-scheme grant checker: top level with sequencer and lane array.
// Depends on dagc_pkg, dagc_lane and dagc_merge.
//
// Input channel (i_s_*): one request per item. tuser carries the mode
// (load available, load claim entry, load allocation entry, request, check);
// tdata carries process, resource, load value and four request counts.
// Output channel (o_m_*): one result per input request, status and echoed
// process id, held in an output register until taken.
// Loads pass the execute and done states before the output register. A
// request that passes the claim and availability checks, and a check item,
// run the safety scan: one lane per process tests its need against the
// working vector in parallel, and the merge stage finishes one process per
// cycle until no lane fits.
// One item is in work at a time; the next is taken as soon as the result
// is in the output register, even if the receiver has not taken it yet.
// A stalled receiver holds the result and, after one more item, the block.
// Reset clears all tables, the available counts and the output valid flag.
module deadlock_avoidance_grant_checker_core import dagc_pkg::*; #(
    parameter int PROCESSES  = PROCESSES_DEF,
    parameter int RESOURCES  = RESOURCES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // process_id[2:0], resource_id[4:3], load_value[12:5], request_0[20:13],
    // request_1[28:21], request_2[36:29], request_3[44:37], zero[47:45]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // mode[2:0]
    input  logic [2:0]             i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // status[2:0], process_echo[5:3], zero[7:6]
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int WORK_BITS = COUNT_BITS + $clog2(PROCESSES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SINIT = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                            r_state, n_state;
    logic [2:0]                            r_mode, n_mode;
    logic [2:0]                            r_pid, n_pid;
    logic [1:0]                            r_rid, n_rid;
    logic [COUNT_BITS-1:0]                 r_val, n_val;
    logic [RESOURCES-1:0][COUNT_BITS-1:0]  r_req, n_req;
    logic [RESOURCES-1:0][COUNT_BITS-1:0]  r_avail, n_avail;
    logic [RESOURCES-1:0][WORK_BITS-1:0]   r_work, n_work;
    logic [2:0]                            r_status, n_status;
    logic                                  r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0]                r_out_data, n_out_data;

    logic [15:0]                           ext_req [REQ_FIELDS];
    logic [15:0]                           ext_val;
    logic                                  in_take;
    logic                                  pid_ok;
    logic                                  claim_bad;
    logic                                  avail_bad;
    logic                                  all_done;
    t_lane_cmd                             lane_cmd;
    logic [PROCESSES-1:0]                  lane_sel;
    logic [PROCESSES-1:0]                  lane_grant;
    logic [PROCESSES-1:0]                  lane_exceeds;
    logic [PROCESSES-1:0]                  lane_fit;
    logic [PROCESSES-1:0]                  lane_done;
    logic [PROCESSES-1:0][RESOURCES-1:0][COUNT_BITS-1:0] lane_alloc;
    logic                                  merge_any;
    logic [PROCESSES-1:0]                  merge_grant;
    logic [RESOURCES-1:0][COUNT_BITS-1:0]  merge_alloc;

    assign o_s_tready = (r_state == S_IDLE);
    assign in_take    = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign ext_val = {8'h00, i_s_tdata[12:5]};
    always_comb begin
        for (int k = 0; k < REQ_FIELDS; k++) begin
            ext_req[k] = {8'h00, i_s_tdata[13 + 8*k +: 8]};
        end
    end

    always_comb begin
        pid_ok    = (32'(r_pid) < PROCESSES);
        claim_bad = !pid_ok;
        avail_bad = 1'b0;
        for (int p = 0; p < PROCESSES; p++) begin
            lane_sel[p] = (32'(r_pid) == p);
            if (lane_sel[p] && lane_exceeds[p]) begin
                claim_bad = 1'b1;
            end
        end
        for (int r = 0; r < RESOURCES; r++) begin
            if (r_req[r] > r_avail[r]) begin
                avail_bad = 1'b1;
            end
        end
        all_done = &lane_done;
    end

    genvar gp;
    generate
        for (gp = 0; gp < PROCESSES; gp++) begin : g_lane
            dagc_lane #(
                .RESOURCES (RESOURCES),
                .COUNT_BITS(COUNT_BITS),
                .WORK_BITS (WORK_BITS)
            ) u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_cmd    (lane_cmd),
                .i_sel    (lane_sel[gp]),
                .i_grant  (lane_grant[gp]),
                .i_rid    (r_rid),
                .i_val    (r_val),
                .i_req    (r_req),
                .i_work   (r_work),
                .o_exceeds(lane_exceeds[gp]),
                .o_fit    (lane_fit[gp]),
                .o_done   (lane_done[gp]),
                .o_alloc  (lane_alloc[gp])
            );
        end
    endgenerate

    dagc_merge #(
        .PROCESSES (PROCESSES),
        .RESOURCES (RESOURCES),
        .COUNT_BITS(COUNT_BITS)
    ) u_merge (
        .i_fit  (lane_fit),
        .i_alloc(lane_alloc),
        .o_grant(merge_grant),
        .o_any  (merge_any),
        .o_alloc(merge_alloc)
    );

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_pid       = r_pid;
        n_rid       = r_rid;
        n_val       = r_val;
        n_req       = r_req;
        n_avail     = r_avail;
        n_work      = r_work;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        lane_cmd    = '0;
        lane_grant  = '0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_mode = i_s_tuser;
                    n_pid  = i_s_tdata[2:0];
                    n_rid  = i_s_tdata[4:3];
                    n_val  = ext_val[COUNT_BITS-1:0];
                    for (int r = 0; r < RESOURCES; r++) begin
                        n_req[r] = (r < REQ_FIELDS) ?
                            ext_req[r & (REQ_FIELDS - 1)][COUNT_BITS-1:0] : '0;
                    end
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = ST_LOAD;
                n_state  = S_DONE;
                unique case (r_mode) inside
                    MODE_AVAIL: begin
                        for (int r = 0; r < RESOURCES; r++) begin
                            if (32'(r_rid) == r) begin
                                n_avail[r] = r_val;
                            end
                        end
                    end
                    MODE_MAX, MODE_ALLOC: begin
                        lane_cmd.wr_max   = (r_mode == MODE_MAX);
                        lane_cmd.wr_alloc = (r_mode == MODE_ALLOC);
                    end
                    MODE_REQ: begin
                        if (claim_bad) begin
                            n_status = ST_CLAIM;
                        end else if (avail_bad) begin
                            n_status = ST_AVAIL;
                        end else begin
                            lane_cmd.add_req = 1'b1;
                            for (int r = 0; r < RESOURCES; r++) begin
                                n_avail[r] = r_avail[r] - r_req[r];
                            end
                            n_state = S_SINIT;
                        end
                    end
                    MODE_CHECK: begin
                        n_state = S_SINIT;
                    end
                    default: begin
                        n_status = ST_LOAD;
                    end
                endcase
            end
            S_SINIT: begin
                lane_cmd.scan_clr = 1'b1;
                for (int r = 0; r < RESOURCES; r++) begin
                    n_work[r] = WORK_BITS'(r_avail[r]);
                end
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (merge_any) begin
                    lane_grant = merge_grant;
                    for (int r = 0; r < RESOURCES; r++) begin
                        n_work[r] = r_work[r] + WORK_BITS'(merge_alloc[r]);
                    end
                end else begin
                    if (all_done) begin
                        n_status = ST_OK;
                    end else begin
                        n_status = ST_UNSAFE;
                        if (r_mode == MODE_REQ) begin
                            // undo the provisional grant
                            lane_cmd.sub_req = 1'b1;
                            for (int r = 0; r < RESOURCES; r++) begin
                                n_avail[r] = r_avail[r] + r_req[r];
                            end
                        end
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {2'b00, r_pid, r_status};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_avail     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_avail     <= n_avail;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_pid      <= n_pid;
        r_rid      <= n_rid;
        r_val      <= n_val;
        r_req      <= n_req;
        r_work     <= n_work;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

endmodule

FILE: hdl/dagc_checker.sv
// Port-level checker for the grant checker core, bound to the top level.
// Depends on dagc_pkg and deadlock_avoidance_grant_checker_core_assert.svh.
`include "deadlock_avoidance_grant_checker_core_assert.svh"

module dagc_checker import dagc_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic [IN_TDATA_W-1:0]  i_s_tdata,
    input logic [2:0]             i_s_tuser,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    `DAGC_AST_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result changed while stalled")
    `DAGC_AST_NOW(a_status_code, o_m_tvalid, (o_m_tdata[2:0] == ST_LOAD) || (o_m_tdata[2:0] == ST_OK) || (o_m_tdata[2:0] == ST_CLAIM) || (o_m_tdata[2:0] == ST_AVAIL) || (o_m_tdata[2:0] == ST_UNSAFE), "undefined status")
    `DAGC_AST_NEXT(a_one_in_flight, i_s_tvalid && o_s_tready, !o_s_tready, "second request taken while busy")
    `DAGC_AST_NOW(a_pad_zero, o_m_tvalid, o_m_tdata[7:6] == 2'b00, "result padding not zero")

endmodule

bind deadlock_avoidance_grant_checker_core dagc_checker u_dagc_checker (.*);
